// ===== rtl/svc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_pkg
// Shared constants, types and helpers of the strided valid 2-D convolution.
// ----------------------------------------------------------------------------
package svc_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_KERNEL = 4;
    localparam int HEIGHT_CAP = 64;
    localparam int LINE_ROWS  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int KCAP       = (MAX_KERNEL < 4) ? MAX_KERNEL : 4;
    localparam int NUM_KROWS  = 4;
    localparam int KROW_W     = 2;

    localparam int PIX_W  = 16;
    localparam int PROD_W = 2 * PIX_W;
    localparam int PSUM_W = PROD_W + $clog2(MAX_KERNEL);
    localparam int SUM_W  = 36;
    localparam int POS_W  = 6;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int SLOT_W = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
    localparam int LINE_W = LINE_ROWS * PIX_W;
    localparam int NWIN   = MAX_KERNEL * MAX_KERNEL;

    localparam int DIM_W     = 7;
    localparam int STR_W     = 3;
    localparam int KS_W      = 3;
    localparam int KREG_W    = 64;
    localparam int APB_AW    = 6;
    localparam int APB_DW    = 64;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_IMG_W  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMG_H  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KSIZE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KROW0  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_KROW1  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_KROW2  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_KROW3  = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [STR_W-1:0] s;
        logic [KS_W-1:0]  k;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0] orow;
        logic [POS_W-1:0] ocol;
        logic             last;
    } t_meta;

    typedef struct packed {
        logic              emit;
        t_meta             meta;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] rmod;
    } t_pos;

    typedef logic [NWIN-1:0][PROD_W-1:0]      t_prod_vec;
    typedef logic [NUM_KROWS-1:0][KREG_W-1:0] t_kernel;

    // true when a 6-bit origin is a multiple of the stride (1..7)
    function automatic logic is_multiple(input logic [POS_W-1:0] x,
                                         input logic [STR_W-1:0] s);
        logic [3:0] t3;
        logic [3:0] t7;
        logic [4:0] t5;
        logic       m3;
        t3 = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]);
        t7 = 4'(x[2:0]) + 4'(x[5:3]);
        t5 = 5'(x[3:0]) + 5'(x[5:4]);
        m3 = (t3 == 4'd0) || (t3 == 4'd3) || (t3 == 4'd6) || (t3 == 4'd9);
        case (s)
            3'd2:    is_multiple = !x[0];
            3'd3:    is_multiple = m3;
            3'd4:    is_multiple = (x[1:0] == 2'd0);
            3'd5:    is_multiple = (t5 == 5'd0) || (t5 == 5'd5) || (t5 == 5'd10) ||
                                   (t5 == 5'd15);
            3'd6:    is_multiple = !x[0] && m3;
            3'd7:    is_multiple = (t7 == 4'd0) || (t7 == 4'd7) || (t7 == 4'd14);
            default: is_multiple = 1'b1;
        endcase
    endfunction

endpackage

// ===== rtl/strided_valid_conv2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_valid_conv2d
// Strided valid-padding 2-D convolution over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one Q8.8 pixel beat per cycle, sustained unless the result stream
// stalls, in raster order; tuser marks the first pixel of an image. For every
// window origin on the stride grid that fits the image, one result beat
// carries the Q20.16 dot product of the K by K window with the kernel, the
// origin row and column, and tlast on the image's last result. The rate is
// set by the line memory (one column word of all buffered rows, read once and
// written back once per pixel); a one-pixel-wide image reuses the same word
// every cycle and is served by forwarding the write-back. The memory needs no
// clearing pass after reset. Registers are written over APB at byte address
// 8 * index and should only change between images.
// ----------------------------------------------------------------------------
module strided_valid_conv2d import svc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // pixel stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [PIX_W-1:0]  s_axis_tdata,   // pixel
    input  logic              s_axis_tuser,   // frame_start
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // conv_sum, origin_row, origin_col
    output logic              m_axis_tlast
);

    logic [DIM_W-1:0]     r_img_w, r_img_h;
    logic [STR_W-1:0]     r_stride;
    logic [KS_W-1:0]      r_ksize;
    t_kernel              r_krow;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr, acc, v2, rdy3;
    t_cfg                 cfg;
    t_pos                 pos;
    t_prod_vec            prod;
    t_meta                meta2, meta_out;
    logic [SUM_W-1:0]     sum_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:APB_AW-REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= DIM_W'(8);
            r_img_h  <= DIM_W'(8);
            r_stride <= STR_W'(1);
            r_ksize  <= KS_W'(4);
            r_krow   <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx) inside
                REG_IMG_W:  r_img_w  <= pwdata[DIM_W-1:0];
                REG_IMG_H:  r_img_h  <= pwdata[DIM_W-1:0];
                REG_STRIDE: r_stride <= pwdata[STR_W-1:0];
                REG_KSIZE:  r_ksize  <= pwdata[KS_W-1:0];
                REG_KROW0, REG_KROW1, REG_KROW2, REG_KROW3:
                    r_krow[reg_idx[KROW_W-1:0]] <= pwdata[KREG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx) inside
            REG_IMG_W:  prdata = APB_DW'(r_img_w);
            REG_IMG_H:  prdata = APB_DW'(r_img_h);
            REG_STRIDE: prdata = APB_DW'(r_stride);
            REG_KSIZE:  prdata = APB_DW'(r_ksize);
            REG_KROW0, REG_KROW1, REG_KROW2, REG_KROW3:
                prdata = APB_DW'(r_krow[reg_idx[KROW_W-1:0]]);
            default:    prdata = '0;
        endcase
    end

    // sizes in use: zero acts as one, oversized values saturate
    always_comb begin
        cfg.w = (r_img_w == '0) ? DIM_W'(1) :
                (r_img_w > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_img_w;
        cfg.h = (r_img_h == '0) ? DIM_W'(1) :
                (r_img_h > DIM_W'(HEIGHT_CAP)) ? DIM_W'(HEIGHT_CAP) : r_img_h;
        cfg.s = (r_stride == '0) ? STR_W'(1) : r_stride;
        cfg.k = (r_ksize == '0) ? KS_W'(1) :
                (r_ksize > KS_W'(KCAP)) ? KS_W'(KCAP) : r_ksize;
    end

    assign acc = s_axis_tvalid && s_axis_tready;

    svc_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_frame_start (s_axis_tuser),
        .i_cfg         (cfg),
        .o_pos         (pos)
    );

    svc_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_pixel  (s_axis_tdata),
        .i_pos    (pos),
        .i_kernel (r_krow),
        .i_ksize  (cfg.k),
        .i_rdy3   (rdy3),
        .o_rdy    (s_axis_tready),
        .o_v2     (v2),
        .o_prod   (prod),
        .o_meta   (meta2)
    );

    svc_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v2    (v2),
        .i_prod  (prod),
        .i_meta  (meta2),
        .o_rdy3  (rdy3),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_sum   (sum_out),
        .o_meta  (meta_out)
    );

    assign m_axis_tdata = {meta_out.ocol, meta_out.orow, sum_out};
    assign m_axis_tlast = meta_out.last;

`ifndef SYNTHESIS
    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid right after reset");

    a_sizes_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg.k != '0) && (cfg.k <= KS_W'(KCAP)) &&
        (cfg.w != '0) && (cfg.w <= DIM_W'(MAX_WIDTH)) &&
        (cfg.h != '0) && (cfg.h <= DIM_W'(HEIGHT_CAP)) && (cfg.s != '0))
        else $error("size in use out of range");

    a_ksize_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && (reg_idx == REG_KSIZE)) |=> (r_ksize == $past(pwdata[KS_W-1:0])))
        else $error("kernel size write lost");
`endif

endmodule

// ===== rtl/svc_line_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_line_ram
// Line buffer memory: one word per column holding all buffered rows.
// ----------------------------------------------------------------------------
module svc_line_ram import svc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_re,
    input  logic [COL_W-1:0]  i_raddr,
    output logic [LINE_W-1:0] o_rdata,
    input  logic              i_we,
    input  logic [COL_W-1:0]  i_waddr,
    input  logic [LINE_W-1:0] i_wdata
);

    logic [LINE_W-1:0] mem [MAX_WIDTH];
    logic [LINE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/svc_pos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_pos
// Raster position counters and window-origin decision for each pixel beat.
// ----------------------------------------------------------------------------
module svc_pos import svc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_acc,
    input  logic i_frame_start,
    input  t_cfg i_cfg,
    output t_pos o_pos
);

    logic [POS_W-1:0]  r_row, n_row, cur_r;
    logic [POS_W-1:0]  r_col, n_col, cur_c;
    logic [SLOT_W-1:0] r_rmod, n_rmod, cur_rm;
    logic [DIM_W-1:0]  r_p1, c_p1, orow_x, ocol_x;
    logic [DIM_W:0]    r_end, c_end;
    logic              fits;

    always_comb begin
        cur_r  = i_frame_start ? '0 : r_row;
        cur_c  = i_frame_start ? '0 : r_col;
        cur_rm = i_frame_start ? '0 : r_rmod;
        r_p1   = {1'b0, cur_r} + 1'b1;
        c_p1   = {1'b0, cur_c} + 1'b1;
        orow_x = r_p1 - DIM_W'(i_cfg.k);
        ocol_x = c_p1 - DIM_W'(i_cfg.k);
        r_end  = (DIM_W+1)'(r_p1) + (DIM_W+1)'(i_cfg.s);
        c_end  = (DIM_W+1)'(c_p1) + (DIM_W+1)'(i_cfg.s);
        fits   = ({1'b0, cur_c} < i_cfg.w) && ({1'b0, cur_r} < i_cfg.h) &&
                 (r_p1 >= DIM_W'(i_cfg.k)) && (c_p1 >= DIM_W'(i_cfg.k));

        o_pos.emit      = fits && is_multiple(orow_x[POS_W-1:0], i_cfg.s) &&
                          is_multiple(ocol_x[POS_W-1:0], i_cfg.s);
        o_pos.meta.orow = orow_x[POS_W-1:0];
        o_pos.meta.ocol = ocol_x[POS_W-1:0];
        // last origin on the grid in both directions
        o_pos.meta.last = (r_end > (DIM_W+1)'(i_cfg.h)) && (c_end > (DIM_W+1)'(i_cfg.w));
        o_pos.col       = cur_c[COL_W-1:0];
        o_pos.rmod      = cur_rm;

        n_col  = c_p1[POS_W-1:0];
        n_row  = cur_r;
        n_rmod = cur_rm;
        if (c_p1 >= i_cfg.w) begin
            n_col = '0;
            if (r_p1 >= i_cfg.h) begin
                n_row  = '0;
                n_rmod = '0;
            end else begin
                n_row  = r_p1[POS_W-1:0];
                n_rmod = (cur_rm == SLOT_W'(LINE_ROWS - 1)) ? '0 : cur_rm + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_rmod <= '0;
        end else if (i_acc) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_rmod <= n_rmod;
        end
    end

endmodule

// ===== rtl/svc_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_window
// Line buffer read-modify-write, K by K window shift and product stage.
// ----------------------------------------------------------------------------
module svc_window import svc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  logic [PIX_W-1:0] i_pixel,
    input  t_pos             i_pos,
    input  t_kernel          i_kernel,
    input  logic [KS_W-1:0]  i_ksize,
    input  logic             i_rdy3,
    output logic             o_rdy,
    output logic             o_v2,
    output t_prod_vec        o_prod,
    output t_meta            o_meta
);

    logic                 r_v1;
    logic [PIX_W-1:0]     r_px1;
    t_pos                 r_pos1;
    logic                 r_byp;
    logic [LINE_W-1:0]    r_byp_data;
    logic [LINE_W-1:0]    mem_rdata, line_rd, wr_word;
    logic [LINE_ROWS-1:0][PIX_W-1:0] tap;

    logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIX_W-1:0] r_win, n_win, coef;
    logic [KS_W-1:0]      koff;
    t_prod_vec            n_prod, r_prod;
    logic                 r_v2;
    t_meta                r_meta2;
    logic                 s1adv, rdy2;

    assign rdy2  = !r_v2 || i_rdy3;
    assign s1adv = r_v1 && rdy2;
    assign o_rdy = !r_v1 || rdy2;

    svc_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_re    (i_acc),
        .i_raddr (i_pos.col),
        .o_rdata (mem_rdata),
        .i_we    (s1adv && (MAX_KERNEL > 1)),
        .i_waddr (r_pos1.col),
        .i_wdata (wr_word)
    );

    // word written back from this read when the pixel stage advances
    always_comb begin
        line_rd = r_byp ? r_byp_data : mem_rdata;
        wr_word = line_rd;
        for (int q = 0; q < LINE_ROWS; q++) begin
            if (r_pos1.rmod == SLOT_W'(q)) begin
                wr_word[q*PIX_W +: PIX_W] = r_px1;
            end
        end
    end

    for (genvar gi = 0; gi < LINE_ROWS; gi++) begin : g_tap
        localparam int OFS = (LINE_ROWS - ((MAX_KERNEL - 1 - gi) % LINE_ROWS)) % LINE_ROWS;
        logic [SLOT_W:0]   slot_sum;
        logic [SLOT_W-1:0] slot;
        assign slot_sum = (SLOT_W+1)'(r_pos1.rmod) + (SLOT_W+1)'(OFS);
        assign slot     = (slot_sum >= (SLOT_W+1)'(LINE_ROWS)) ?
                          SLOT_W'(slot_sum - (SLOT_W+1)'(LINE_ROWS)) : slot_sum[SLOT_W-1:0];
        assign tap[gi]  = line_rd[slot*PIX_W +: PIX_W];
    end

    always_comb begin
        n_win = r_win;
        for (int i = 0; i < MAX_KERNEL; i++) begin
            for (int j = 0; j + 1 < MAX_KERNEL; j++) begin
                n_win[i][j] = r_win[i][j+1];
            end
        end
        for (int i = 0; i + 1 < MAX_KERNEL; i++) begin
            n_win[i][MAX_KERNEL-1] = tap[i];
        end
        n_win[MAX_KERNEL-1][MAX_KERNEL-1] = r_px1;
    end

    // kernel sits in the bottom-right K by K corner of the window
    assign koff = KS_W'(MAX_KERNEL) - i_ksize;

    always_comb begin
        logic [KS_W-1:0] ai;
        logic [KS_W-1:0] bi;
        coef = '0;
        for (int i = 0; i < MAX_KERNEL; i++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
                ai = KS_W'(i) - koff;
                bi = KS_W'(j) - koff;
                if ((KS_W'(i) >= koff) && (KS_W'(j) >= koff)) begin
                    coef[i][j] = i_kernel[ai[KROW_W-1:0]][bi[KROW_W-1:0]*PIX_W +: PIX_W];
                end
            end
        end
    end

    // taps outside the kernel may hold never-written line entries
    always_comb begin
        for (int i = 0; i < MAX_KERNEL; i++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
                if ((KS_W'(i) >= koff) && (KS_W'(j) >= koff)) begin
                    n_prod[i*MAX_KERNEL+j] = $signed(n_win[i][j]) * $signed(coef[i][j]);
                end else begin
                    n_prod[i*MAX_KERNEL+j] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_byp <= 1'b0;
        end else begin
            if (i_acc) begin
                r_v1 <= 1'b1;
            end else if (s1adv) begin
                r_v1 <= 1'b0;
            end
            if (s1adv) begin
                r_v2 <= r_pos1.emit;
            end else if (i_rdy3) begin
                r_v2 <= 1'b0;
            end
            if (i_acc) begin
                r_byp <= s1adv && (i_pos.col == r_pos1.col);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_px1      <= i_pixel;
            r_pos1     <= i_pos;
            r_byp_data <= wr_word;
        end
        if (s1adv) begin
            r_win <= n_win;
        end
        if (s1adv && r_pos1.emit) begin
            r_prod  <= n_prod;
            r_meta2 <= r_pos1.meta;
        end
    end

    assign o_v2   = r_v2;
    assign o_prod = r_prod;
    assign o_meta = r_meta2;

endmodule

// ===== rtl/svc_sum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_sum
// Two-level registered adder tree and output register of the result beat.
// ----------------------------------------------------------------------------
module svc_sum import svc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_v2,
    input  t_prod_vec        i_prod,
    input  t_meta            i_meta,
    output logic             o_rdy3,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [SUM_W-1:0] o_sum,
    output t_meta            o_meta
);

    logic                                r_v3, r_v4, rdy4, adv3;
    logic [MAX_KERNEL-1:0][PSUM_W-1:0]   r_psum, n_psum;
    t_meta                               r_meta3, r_meta4;
    logic [SUM_W-1:0]                    r_sum, n_sum;

    assign rdy4   = !r_v4 || i_ready;
    assign o_rdy3 = !r_v3 || rdy4;
    assign adv3   = r_v3 && rdy4;

    // row sums
    always_comb begin
        logic signed [PSUM_W-1:0] acc;
        for (int i = 0; i < MAX_KERNEL; i++) begin
            acc = '0;
            for (int j = 0; j < MAX_KERNEL; j++) begin
                acc = acc + PSUM_W'($signed(i_prod[i*MAX_KERNEL+j]));
            end
            n_psum[i] = acc;
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] tot;
        tot = '0;
        for (int i = 0; i < MAX_KERNEL; i++) begin
            tot = tot + SUM_W'($signed(r_psum[i]));
        end
        n_sum = tot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (o_rdy3) begin
                r_v3 <= i_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy3 && i_v2) begin
            r_psum  <= n_psum;
            r_meta3 <= i_meta;
        end
        if (adv3) begin
            r_sum   <= n_sum;
            r_meta4 <= r_meta3;
        end
    end

    assign o_valid = r_v4;
    assign o_sum   = r_sum;
    assign o_meta  = r_meta4;

endmodule
